/* sv/vpw_pkg.sv */
// vpw_pkg: shared types and constants of the vertex-to-window projection block
// used by vpw_front, vpw_back and vertex_project_to_window; no dependencies
package vpw_pkg;

   // item kinds carried on req_tuser
   typedef enum logic {
      OP_WRITE_COEF = 1'b0,
      OP_PROJECT    = 1'b1
   } opcode_type;

   // configuration register indexes
   localparam logic [1:0] REG_ORIGIN_X = 2'd0;
   localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
   localparam logic [1:0] REG_WIDTH    = 2'd2;
   localparam logic [1:0] REG_HEIGHT   = 2'd3;

   localparam int QUEUE_DEPTH   = 4;
   localparam int STORE_DEPTH   = 32;
   localparam int IN_DATA_BITS  = 136;
   localparam int OUT_DATA_BITS = 96;

   // queue head control seen by the back part
   typedef struct packed {
      logic       valid;
      opcode_type kind;
      logic [4:0] idx;
   } head_ctl_type;

endpackage

/* sv/vpw_front.sv */
// vpw_front: accepts request transfers, saturates the fields to the internal word
// and holds them in a short queue; depends on vpw_pkg
module vpw_front #(
   parameter int W = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // coef_index[4:0], coef_value[36:5], obj_x[68:37], obj_y[100:69], obj_z[132:101]
   input  logic [vpw_pkg::IN_DATA_BITS-1:0]    req_tdata,
   // opcode[0]
   input  logic                                req_tuser,
   output vpw_pkg::head_ctl_type               head_ctl,
   output logic [W-1:0]                        head_val,
   output logic [W-1:0]                        head_x,
   output logic [W-1:0]                        head_y,
   output logic [W-1:0]                        head_z,
   input  logic                                pop
);
   import vpw_pkg::*;

   localparam int IW = (W > 32) ? W : 32;
   localparam int EW = 6 + 4 * W;
   localparam int PTRW = $clog2(QUEUE_DEPTH);
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   // saturate a 32-bit field into the internal word
   function automatic logic [W-1:0] sat_in(input logic signed [31:0] v);
      logic signed [IW-1:0] e;
      logic signed [IW-1:0] hi;
      e  = IW'(v);
      hi = IW'(signed'({1'b0, {(W-1){1'b1}}}));
      if (e > hi) return {1'b0, {(W-1){1'b1}}};
      if (e < ~hi) return {1'b1, {(W-1){1'b0}}};
      return e[W-1:0];
   endfunction

   logic [EW-1:0]   q_ff [QUEUE_DEPTH];
   logic [PTRW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNTW-1:0] count_ff, count_in;
   logic            push;
   logic [EW-1:0]   entry_in, head;

   assign req_tready = (count_ff < CNTW'(QUEUE_DEPTH));
   assign push = req_tvalid && req_tready;

   // classify and pack the incoming transfer
   assign entry_in = {req_tuser, req_tdata[4:0],
                      sat_in(req_tdata[36:5]), sat_in(req_tdata[68:37]),
                      sat_in(req_tdata[100:69]), sat_in(req_tdata[132:101])};

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + CNTW'(1);
      else if (!push && pop) count_in = count_ff - CNTW'(1);
   end

   // queue pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTRW'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + PTRW'(1);
         count_ff <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= entry_in;
   end

   // head of queue
   assign head           = q_ff[rd_ptr_ff];
   assign head_ctl.valid = (count_ff != '0);
   assign head_ctl.kind  = opcode_type'(head[EW-1]);
   assign head_ctl.idx   = head[EW-2:EW-6];
   assign head_val       = head[4*W-1:3*W];
   assign head_x         = head[3*W-1:2*W];
   assign head_y         = head[2*W-1:W];
   assign head_z         = head[W-1:0];

endmodule

/* sv/vpw_back.sv */
// vpw_back: coefficient store and the projection pipeline (two matrix products,
// pipelined reciprocal, perspective scale, viewport map); depends on vpw_pkg
module vpw_back #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  vpw_pkg::head_ctl_type               head_ctl,
   input  logic [W-1:0]                        head_val,
   input  logic [W-1:0]                        head_x,
   input  logic [W-1:0]                        head_y,
   input  logic [W-1:0]                        head_z,
   output logic                                pop,
   input  logic signed [15:0]                  origin_x,
   input  logic signed [15:0]                  origin_y,
   input  logic [14:0]                         size_x,
   input  logic [14:0]                         size_y,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // win_x[31:0], win_y[63:32], win_depth[95:64]
   output logic [vpw_pkg::OUT_DATA_BITS-1:0]   rsp_tdata,
   // degenerate[0]
   output logic                                rsp_tuser
);
   import vpw_pkg::*;

   localparam int NB = ((2 * F > W - 1) ? 2 * F : W - 1) + 1;
   localparam int PW = W + 16;
   localparam int VW = ((W > F) ? W : F) + 18;
   localparam int XW = (W > 32) ? W : 32;
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] ONE  = (F < W - 1) ? (W'(1) << F) : WMAX;

   // saturate a wide value into the word
   function automatic logic signed [W-1:0] sat_vw(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] hi;
      hi = VW'(WMAX);
      if (v > hi) return WMAX;
      if (v < ~hi) return ~WMAX;
      return v[W-1:0];
   endfunction

   // round a raw product to nearest, ties away from zero, and saturate
   function automatic logic signed [W-1:0] qround(input logic signed [2*W-1:0] p);
      logic           neg;
      logic [2*W:0]   m;
      logic [2*W:0]   lim;
      neg = p[2*W-1];
      m   = {1'b0, (neg ? -p : p)};
      m   = (m + ((2*W+1)'(1) << (F - 1))) >> F;
      lim = (2*W+1)'({1'b0, WMAX}) + (2*W+1)'(neg);
      if (m > lim) m = lim;
      return neg ? W'(-m) : W'(m);
   endfunction

   // halve, rounding to nearest, ties away from zero
   function automatic logic signed [VW-1:0] half_rnd(input logic signed [VW-1:0] v);
      logic [VW-1:0] m;
      m = v[VW-1] ? -v : v;
      m = (m + VW'(1)) >> 1;
      return v[VW-1] ? -m : m;
   endfunction

   // saturate the word to 32 bits
   function automatic logic [31:0] to32(input logic signed [W-1:0] v);
      logic signed [XW-1:0] e;
      logic signed [XW-1:0] hi;
      e  = XW'(v);
      hi = XW'(32'sh7fffffff);
      if (e > hi) return 32'h7fffffff;
      if (e < ~hi) return 32'h80000000;
      return e[31:0];
   endfunction

   logic en, store_we;

   logic signed [W-1:0]   coef_ff [STORE_DEPTH];
   logic                  v0_ff, v1_ff, v2_ff, v3_ff;
   logic signed [W-1:0]   obj_ff [4];
   logic signed [2*W-1:0] mp_ff [4][4];
   logic signed [W-1:0]   eye_ff [4];
   logic signed [W-1:0]   eye_in [4];
   logic signed [2*W-1:0] pp_ff [3][4];
   logic signed [W-1:0]   nd_ff;

   logic                  dv_v_ff [NB+1];
   logic [W-1:0]          dv_r_ff [NB+1];
   logic [NB-1:0]         dv_nq_ff [NB+1];
   logic [W-1:0]          dv_ud_ff [NB+1];
   logic                  dv_neg_ff [NB+1];
   logic                  dv_zero_ff [NB+1];
   logic signed [W-1:0]   dv_clip_ff [NB+1][3];
   logic signed [W-1:0]   clip_in [3];
   logic [W-1:0]          ud_in;

   logic                  rc_v_ff, rc_zero_ff;
   logic signed [W-1:0]   rc_recip_ff, qs_in;
   logic signed [W-1:0]   rc_clip_ff [3];
   logic                  nm_v_ff, nm_zero_ff;
   logic signed [2*W-1:0] nm_ff [3];
   logic                  nc_v_ff, nc_zero_ff;
   logic signed [W-1:0]   ndc_ff [3];
   logic                  wp_v_ff, wp_zero_ff;
   logic signed [PW-1:0]  wp_ff [3];
   logic signed [15:0]    sz [3];
   logic signed [15:0]    org [3];
   logic                  rsp_valid_ff, rsp_user_ff;
   logic [31:0]           rsp_data_ff [3];
   logic [31:0]           win_in [3];

   // pipeline advances unless the output register is held
   assign en = !rsp_valid_ff || rsp_tready;

   // writes wait until no vertex still has to read the store
   assign pop = en && head_ctl.valid &&
                ((head_ctl.kind == OP_PROJECT) || !(v0_ff || v1_ff || v2_ff));
   assign store_we = pop && (head_ctl.kind == OP_WRITE_COEF);

   // coefficient store
   always_ff @(posedge clock) begin
      if (store_we) coef_ff[head_ctl.idx] <= head_val;
   end

   // sums of rounded products and divider entry values
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         eye_in[r] = sat_vw(VW'(qround(mp_ff[r][0])) + VW'(qround(mp_ff[r][1])) +
                            VW'(qround(mp_ff[r][2])) + VW'(qround(mp_ff[r][3])));
      end
      for (int r = 0; r < 3; r++) begin
         clip_in[r] = sat_vw(VW'(qround(pp_ff[r][0])) + VW'(qround(pp_ff[r][1])) +
                             VW'(qround(pp_ff[r][2])) + VW'(qround(pp_ff[r][3])));
      end
      ud_in = nd_ff[W-1] ? W'(-nd_ff) : W'(nd_ff);
      qs_in = (dv_nq_ff[NB] > NB'({1'b0, WMAX})) ? WMAX : W'(dv_nq_ff[NB]);
   end

   // valid bits of the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int k = 0; k <= NB; k++) dv_v_ff[k] <= 1'b0;
         rc_v_ff <= 1'b0;
         nm_v_ff <= 1'b0;
         nc_v_ff <= 1'b0;
         wp_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= pop && (head_ctl.kind == OP_PROJECT);
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         dv_v_ff[0] <= v3_ff;
         for (int k = 0; k < NB; k++) dv_v_ff[k+1] <= dv_v_ff[k];
         rc_v_ff <= dv_v_ff[NB];
         nm_v_ff <= rc_v_ff;
         nc_v_ff <= nm_v_ff;
         wp_v_ff <= nc_v_ff;
         rsp_valid_ff <= wp_v_ff;
      end
   end

   // model-view and projection products
   always_ff @(posedge clock) begin
      if (en) begin
         obj_ff[0] <= head_x;
         obj_ff[1] <= head_y;
         obj_ff[2] <= head_z;
         obj_ff[3] <= ONE;
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) mp_ff[r][c] <= coef_ff[c*4+r] * obj_ff[c];
         end
         for (int r = 0; r < 4; r++) eye_ff[r] <= eye_in[r];
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) pp_ff[r][c] <= coef_ff[16+c*4+r] * eye_ff[c];
         end
         nd_ff <= sat_vw(-VW'(eye_ff[2]));
      end
   end

   // reciprocal of the eye depth, one quotient bit per stage
   always_ff @(posedge clock) begin
      if (en) begin
         dv_r_ff[0]    <= '0;
         dv_nq_ff[0]   <= (NB'(1) << (2 * F)) + NB'(ud_in >> 1);
         dv_ud_ff[0]   <= ud_in;
         dv_neg_ff[0]  <= nd_ff[W-1];
         dv_zero_ff[0] <= (nd_ff == '0);
         for (int r = 0; r < 3; r++) dv_clip_ff[0][r] <= clip_in[r];
         for (int k = 0; k < NB; k++) begin
            if ({dv_r_ff[k], dv_nq_ff[k][NB-1]} >= {1'b0, dv_ud_ff[k]}) begin
               dv_r_ff[k+1]  <= W'({dv_r_ff[k], dv_nq_ff[k][NB-1]} - {1'b0, dv_ud_ff[k]});
               dv_nq_ff[k+1] <= {dv_nq_ff[k][NB-2:0], 1'b1};
            end else begin
               dv_r_ff[k+1]  <= {dv_r_ff[k][W-2:0], dv_nq_ff[k][NB-1]};
               dv_nq_ff[k+1] <= {dv_nq_ff[k][NB-2:0], 1'b0};
            end
            dv_ud_ff[k+1]   <= dv_ud_ff[k];
            dv_neg_ff[k+1]  <= dv_neg_ff[k];
            dv_zero_ff[k+1] <= dv_zero_ff[k];
            for (int r = 0; r < 3; r++) dv_clip_ff[k+1][r] <= dv_clip_ff[k][r];
         end
      end
   end

   // viewport sizes and origins, depth uses unit size and zero origin
   assign sz[0]  = {1'b0, size_x};
   assign sz[1]  = {1'b0, size_y};
   assign sz[2]  = 16'sd1;
   assign org[0] = origin_x;
   assign org[1] = origin_y;
   assign org[2] = 16'sd0;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r] = to32(sat_vw((VW'(org[r]) <<< F) + half_rnd(VW'(wp_ff[r]))));
      end
   end

   // perspective scale and viewport map
   always_ff @(posedge clock) begin
      if (en) begin
         rc_recip_ff <= dv_neg_ff[NB] ? -qs_in : qs_in;
         rc_zero_ff  <= dv_zero_ff[NB];
         for (int r = 0; r < 3; r++) rc_clip_ff[r] <= dv_clip_ff[NB][r];
         for (int r = 0; r < 3; r++) nm_ff[r] <= rc_clip_ff[r] * rc_recip_ff;
         nm_zero_ff <= rc_zero_ff;
         for (int r = 0; r < 3; r++) ndc_ff[r] <= qround(nm_ff[r]);
         nc_zero_ff <= nm_zero_ff;
         // the sum with the unit added here is saturated to the word
         for (int r = 0; r < 3; r++) begin
            wp_ff[r] <= sat_vw(VW'(ndc_ff[r]) + (VW'(1) <<< F)) * sz[r];
         end
         wp_zero_ff <= nc_zero_ff;
         for (int r = 0; r < 3; r++) rsp_data_ff[r] <= wp_zero_ff ? 32'h0 : win_in[r];
         rsp_user_ff <= wp_zero_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff[2], rsp_data_ff[1], rsp_data_ff[0]};
   assign rsp_tuser  = rsp_user_ff;

   // store is never written under a vertex that still reads it
   a_store_hazard: assert property (@(posedge clock) disable iff (reset)
      store_we |-> !(v0_ff || v1_ff || v2_ff))
      else $error("coefficient write overlaps a vertex in flight");

   // degenerate results carry zero coordinates
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("degenerate result with nonzero coordinates");

   // a held output freezes the end of the divider
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(dv_v_ff[NB]) && $stable(wp_v_ff))
      else $error("pipeline moved while output stalled");

endmodule

/* sv/vertex_project_to_window.sv */
// vertex_project_to_window: top level with the configuration registers,
// the front queue and the projection pipeline; depends on vpw_pkg, vpw_front, vpw_back
//
// Usage: request transfers on req_* carry either a coefficient write (req_tuser = 0,
// slots 0-15 model-view, 16-31 projection, column-major) or a vertex (req_tuser = 1).
// Each vertex gives one result transfer on rsp_*; writes give none. Results come out
// in request order. The viewport is set through the csr_* port while the block is idle, a
// rule for the user that the block itself does not enforce. Throughput: one vertex per
// cycle while rsp_tready does not hold the output. From the queue head a vertex passes the
// operand register, both matrix products, the reciprocal pipeline that resolves one quotient
// bit per stage, the perspective scale and the viewport map into the output register. A
// coefficient write leaves the queue only once no vertex ahead of it still reads the store.
// Reset clears the queue, the pipeline valid bits and the viewport registers; the
// coefficient store is not cleared and must be written before use.
// While a result waits with rsp_tready low the whole pipeline holds; the four-entry
// queue keeps accepting until it is full.
module vertex_project_to_window #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // coef_index[4:0], coef_value[36:5], obj_x[68:37], obj_y[100:69], obj_z[132:101]
   input  logic [vpw_pkg::IN_DATA_BITS-1:0]    req_tdata,
   // opcode[0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // win_x[31:0], win_y[63:32], win_depth[95:64]
   output logic [vpw_pkg::OUT_DATA_BITS-1:0]   rsp_tdata,
   // degenerate[0]
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [3:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import vpw_pkg::*;

   logic signed [15:0] origin_x_ff, origin_y_ff;
   logic [14:0]        width_ff, height_ff;
   logic               csr_we;
   head_ctl_type       head_ctl;
   logic [WORD_BITS-1:0] head_val, head_x, head_y, head_z;
   logic               pop;

   assign csr_pready = 1'b1;
   assign csr_we = csr_psel && csr_penable && csr_pwrite;

   // viewport registers
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
      end else if (csr_we) begin
         case (csr_paddr[3:2])
            REG_ORIGIN_X: origin_x_ff <= csr_pwdata[15:0];
            REG_ORIGIN_Y: origin_y_ff <= csr_pwdata[15:0];
            REG_WIDTH:    width_ff    <= csr_pwdata[14:0];
            REG_HEIGHT:   height_ff   <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (csr_paddr[3:2])
         REG_ORIGIN_X: csr_prdata = {16'h0, origin_x_ff};
         REG_ORIGIN_Y: csr_prdata = {16'h0, origin_y_ff};
         REG_WIDTH:    csr_prdata = {17'h0, width_ff};
         REG_HEIGHT:   csr_prdata = {17'h0, height_ff};
         default:      csr_prdata = 32'h0;
      endcase
   end

   vpw_front #(.W(WORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head_ctl   (head_ctl),
      .head_val   (head_val),
      .head_x     (head_x),
      .head_y     (head_y),
      .head_z     (head_z),
      .pop        (pop)
   );

   vpw_back #(.W(WORD_BITS), .F(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_ctl   (head_ctl),
      .head_val   (head_val),
      .head_x     (head_x),
      .head_y     (head_y),
      .head_z     (head_z),
      .pop        (pop),
      .origin_x   (origin_x_ff),
      .origin_y   (origin_y_ff),
      .size_x     (width_ff),
      .size_y     (height_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* sim/tb.sv */
// tb: self-checking testbench for vertex_project_to_window
// drives coefficient writes and vertices on req_*, checks rsp_* against an in-bench predictor
// depends on vpw_pkg and vertex_project_to_window
`timescale 1ns / 1ps

module tb;
   import vpw_pkg::*;

   localparam int FRAC = 16;
   localparam longint WMAX = 64'sd2147483647;
   localparam longint WMIN = -64'sd2147483648;
   localparam int LAT = 2 * FRAC + 11;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [31:0] wx;
      logic [31:0] wy;
      logic [31:0] wz;
      logic        degen;
   } window_pt_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_DATA_BITS-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_DATA_BITS-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // predictor state
   longint coef_mem [32];
   longint vp_ox, vp_oy, vp_w, vp_h;
   window_pt_type pending_pts [$];
   int  errors = 0;
   int  cycles = 0;
   int  stall_mode = 0;
   int  burst_left = 0;

   vertex_project_to_window #(.FRAC_BITS(16), .WORD_BITS(32)) u_top (.*);

   always #5 clock = ~clock;

   function automatic longint sat_w(longint v);
      if (v > WMAX) return WMAX;
      if (v < WMIN) return WMIN;
      return v;
   endfunction

   // rounded q16.16 product, ties away from zero; inputs fit in 33 bits so 128 bits suffice
   function automatic longint fx_mul(longint a, longint b);
      logic signed [127:0] p;
      logic [127:0] m;
      logic neg;
      p = 128'(signed'(a)) * 128'(signed'(b));
      neg = p[127];
      m = neg ? -p : p;
      m = (m + (128'd1 << (FRAC - 1))) >> FRAC;
      if (neg) begin
         if (m > 128'd2147483648) m = 128'd2147483648;
         return -longint'(m[63:0]);
      end
      if (m > 128'd2147483647) m = 128'd2147483647;
      return longint'(m[63:0]);
   endfunction

   function automatic longint half_rnd(longint v);
      longint m;
      m = ((v < 0 ? -v : v) + 1) >>> 1;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint mat_row(int base, int r, longint v0, longint v1,
                                      longint v2, longint v3);
      longint s;
      s = fx_mul(coef_mem[base + r], v0) + fx_mul(coef_mem[base + 4 + r], v1)
        + fx_mul(coef_mem[base + 8 + r], v2) + fx_mul(coef_mem[base + 12 + r], v3);
      return sat_w(s);
   endfunction

   function automatic longint map_window(longint org, longint size, longint ndc);
      longint t;
      t = sat_w(ndc + (64'sd1 <<< FRAC));
      return sat_w(org * (64'sd1 <<< FRAC) + half_rnd(t * size));
   endfunction

   function automatic window_pt_type project_vertex(longint x, longint y, longint z);
      window_pt_type pt;
      longint e0, e1, e2, e3, c0, c1, c2, d, q, ud, rc, one;
      one = 64'sd1 <<< FRAC;
      e0 = mat_row(0, 0, x, y, z, one);
      e1 = mat_row(0, 1, x, y, z, one);
      e2 = mat_row(0, 2, x, y, z, one);
      e3 = mat_row(0, 3, x, y, z, one);
      c0 = mat_row(16, 0, e0, e1, e2, e3);
      c1 = mat_row(16, 1, e0, e1, e2, e3);
      c2 = mat_row(16, 2, e0, e1, e2, e3);
      d = sat_w(-e2);
      pt = '0;
      if (d == 0) begin
         pt.degen = 1'b1;
         return pt;
      end
      ud = d < 0 ? -d : d;
      q = ((64'sd1 <<< (2 * FRAC)) + (ud >>> 1)) / ud;
      if (q > WMAX) q = WMAX;
      rc = d < 0 ? -q : q;
      pt.wx = 32'(map_window(vp_ox, vp_w, fx_mul(c0, rc)));
      pt.wy = 32'(map_window(vp_oy, vp_h, fx_mul(c1, rc)));
      pt.wz = 32'(map_window(0, 1, fx_mul(c2, rc)));
      return pt;
   endfunction

   // sender gap pattern: bursts with random gaps, valid drops only during a gap
   task automatic sender_gap();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_item(opcode_type op, logic [4:0] idx, logic [31:0] val,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z);
      if (op == OP_PROJECT) begin
         pending_pts.push_back(project_vertex(longint'(signed'(x)), longint'(signed'(y)),
                                              longint'(signed'(z))));
      end else begin
         coef_mem[idx] = longint'(signed'(val));
      end
      sender_gap();
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {3'b0, z, y, x, val, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_pts.size() != 0) @(posedge clock);
      repeat (LAT + 8) @(posedge clock);
   endtask

   // one write transfer; the bus is released by the caller after the last one
   task automatic csr_write(logic [1:0] reg_idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (reg_idx)
         REG_ORIGIN_X: vp_ox = longint'(signed'(val[15:0]));
         REG_ORIGIN_Y: vp_oy = longint'(signed'(val[15:0]));
         REG_WIDTH:    vp_w = longint'(val[14:0]);
         REG_HEIGHT:   vp_h = longint'(val[14:0]);
         default: ;
      endcase
   endtask

   task automatic set_viewport(logic [31:0] ox, logic [31:0] oy, logic [31:0] w,
                               logic [31:0] h);
      wait_idle();
      csr_write(REG_ORIGIN_X, ox);
      csr_write(REG_ORIGIN_Y, oy);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic write_coef(int idx, logic [31:0] val);
      send_item(OP_WRITE_COEF, 5'(idx), val, $urandom, $urandom, $urandom);
   endtask

   // identity model-view and identity projection matrices
   task automatic load_camera();
      for (int i = 0; i < 32; i++) begin
         write_coef(i, (i % 16) % 5 == 0 ? 32'h0001_0000 : 32'h0);
      end
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h7fff_ffff;
         2: return 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
      endcase
   endfunction

   task automatic test_directed();
      set_viewport(32'h0, 32'h0, 32'd640, 32'd480);
      load_camera();
      // zero eye z gives the degenerate flag
      send_item(OP_PROJECT, 5'd31, 32'hffff_ffff, 32'h0001_0000, 32'h0002_0000, 32'h0);
      send_item(OP_PROJECT, 5'd0, 32'h0, 32'h0, 32'h0, 32'hffff_0000);
      send_item(OP_PROJECT, 5'd0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000);
      send_item(OP_PROJECT, 5'd0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send_item(OP_PROJECT, 5'd0, 32'h0, 32'h0000_0001, 32'hffff_ffff, 32'h8000_0000);
      send_item(OP_PROJECT, 5'd0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0000_0001);
      // extreme coefficients, then a vertex right after the write
      write_coef(10, 32'h7fff_ffff);
      send_item(OP_PROJECT, 5'd0, 32'h0, 32'h0003_0000, 32'h0001_0000, 32'hfffe_0000);
      write_coef(26, 32'h8000_0000);
      send_item(OP_PROJECT, 5'd0, 32'h0, 32'h0003_0000, 32'h0001_0000, 32'hfffe_0000);
      set_viewport(32'h8000, 32'h7fff, 32'h7fff, 32'h7fff);
      send_item(OP_PROJECT, 5'd0, 32'h0, 32'h0003_0000, 32'hffff_0000, 32'h0001_0000);
      send_item(OP_PROJECT, 5'd0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
   endtask

   task automatic test_random(int n_items);
      int kind;
      for (int i = 0; i < n_items; i++) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            write_coef($urandom_range(0, 31), $urandom);
         end else if (kind == 1) begin
            write_coef($urandom_range(0, 31),
                       32'($signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000));
         end else begin
            send_item(OP_PROJECT, 5'($urandom), $urandom, rand_coord(), rand_coord(),
                      rand_coord());
         end
      end
   endtask

   task automatic test_viewports();
      set_viewport(32'h0, 32'h0, 32'h0, 32'h0);
      test_random(300);
      set_viewport(32'hffff_8000, 32'h0000_8000, 32'd1920, 32'd1080);
      load_camera();
      test_random(400);
      set_viewport($urandom, $urandom, $urandom, $urandom);
      test_random(450);
      set_viewport(32'h7fff, 32'hffff_8000, 32'h7fff, 32'h0);
      test_random(400);
   endtask

   // receiver stall pattern and checker
   always @(posedge clock) begin
      window_pt_type exp_pt;
      cycles <= cycles + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pts.size() == 0) begin
               $error("unexpected result transfer");
               errors++;
            end else begin
               exp_pt = pending_pts.pop_front();
               if (rsp_tdata[31:0] !== exp_pt.wx) begin
                  $error("win_x expected %h actual %h", exp_pt.wx, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[63:32] !== exp_pt.wy) begin
                  $error("win_y expected %h actual %h", exp_pt.wy, rsp_tdata[63:32]);
                  errors++;
               end
               if (rsp_tdata[95:64] !== exp_pt.wz) begin
                  $error("win_depth expected %h actual %h", exp_pt.wz, rsp_tdata[95:64]);
                  errors++;
               end
               if (rsp_tuser !== exp_pt.degen) begin
                  $error("degenerate expected %b actual %b", exp_pt.degen, rsp_tuser);
                  errors++;
               end
            end
         end
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 3) != 0;
            default: rsp_tready <= cycles[3:0] < 4'd11;
         endcase
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      vp_ox = 0; vp_oy = 0; vp_w = 0; vp_h = 0;
      foreach (coef_mem[i]) begin
         coef_mem[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_viewports();
      wait_idle();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
